/* hdl/spool_pkg.sv */
// Shared types and constants for the sum pooling block.
// Used by every file of the block but spool_ram; it depends on nothing else.
package spool_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int MAX_KERNEL = 8;
  localparam int DATA_WIDTH = 16;

  localparam int STRIDE_MAX = 8;
  localparam int SUM_WIDTH  = 22;
  localparam int SUM_MAX    = 2097151;
  localparam int SUM_MIN    = -2097152;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 7;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IN_HEIGHT,
    REG_IN_WIDTH,
    REG_KERNEL_HEIGHT,
    REG_KERNEL_WIDTH,
    REG_STRIDE_ROWS,
    REG_STRIDE_COLS,
    REG_PAD_ROWS,
    REG_PAD_COLS
  } cfg_reg_e;

  localparam logic [6:0] RST_IN_HEIGHT     = 7'd64;
  localparam logic [6:0] RST_IN_WIDTH      = 7'd64;
  localparam logic [3:0] RST_KERNEL_HEIGHT = 4'd2;
  localparam logic [3:0] RST_KERNEL_WIDTH  = 4'd2;
  localparam logic [3:0] RST_STRIDE_ROWS   = 4'd2;
  localparam logic [3:0] RST_STRIDE_COLS   = 4'd2;
  localparam logic [2:0] RST_PAD_ROWS      = 3'd0;
  localparam logic [2:0] RST_PAD_COLS      = 3'd0;

  // Register values after range limiting, as the datapath uses them.
  typedef struct packed {
    logic [6:0] h;
    logic [6:0] w;
    logic [3:0] kh;
    logic [3:0] kw;
    logic [3:0] sh;
    logic [3:0] sw;
    logic [2:0] ph;
    logic [2:0] pw;
  } cfg_t;

endpackage

/* hdl/spool_ifs.sv */
// Valid/ready channel interfaces of the sum pooling block: request, response
// and register write. Depends on spool_pkg for the register port widths.
interface spool_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic        [6:0]  row;
  logic        [6:0]  col;
  logic signed [15:0] pixel;

  modport source (output valid, command, row, col, pixel, input ready);
  modport sink   (input valid, command, row, col, pixel, output ready);
endinterface

interface spool_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [21:0] window_sum;
  logic               status;

  modport source (output valid, window_sum, status, input ready);
  modport sink   (input valid, window_sum, status, output ready);
endinterface

interface spool_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [spool_pkg::CFG_INDEX_W-1:0]   index;
  logic [spool_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/sum_pooling_2d.sv */
// Top level of the sum pooling block: register file, request sequencer and
// frame RAM. Depends on spool_pkg, spool_ifs, spool_ram, spool_cfg, spool_core.
//
//   Channel  Dir   Handshake      Contents
//   req_i    in    valid/ready    command, row, col, pixel
//   rsp_o    out   valid/ready    window_sum, status
//   cfg_i    in    valid/ready    register index, write data
//
// A compute request walks the window in ST_RUN, one frame RAM read per
// window position inside the image on its single read port; a coordinate
// outside the output grid skips ST_RUN. The result sits in an output
// register, so the next request is taken while it waits. Reset restores
// the register defaults; the frame RAM holds no reset value and must be
// written before it is read.
module sum_pooling_2d #(
  parameter int MAX_ROWS   = spool_pkg::MAX_ROWS,
  parameter int MAX_COLS   = spool_pkg::MAX_COLS,
  parameter int MAX_KERNEL = spool_pkg::MAX_KERNEL,
  parameter int DATA_WIDTH = spool_pkg::DATA_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spool_req_if.sink   req_i,
  spool_rsp_if.source rsp_o,
  spool_cfg_if.sink   cfg_i
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  spool_pkg::cfg_t       cfg;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  spool_cfg #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  spool_core #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_KERNEL (MAX_KERNEL),
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  spool_ram #(
    .WIDTH  (DATA_WIDTH),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

/* hdl/spool_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module spool_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/spool_cfg.sv */
// Configuration register file with range limiting of each size, kernel and stride register at use.
// Depends on spool_pkg and the spool_cfg_if interface.
module spool_cfg #(
  parameter int MAX_ROWS   = spool_pkg::MAX_ROWS,
  parameter int MAX_COLS   = spool_pkg::MAX_COLS,
  parameter int MAX_KERNEL = spool_pkg::MAX_KERNEL
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  spool_cfg_if.sink       cfg_i,
  output spool_pkg::cfg_t cfg_o
);

  logic [6:0] in_height_q, in_width_q;
  logic [3:0] kernel_height_q, kernel_width_q, stride_rows_q, stride_cols_q;
  logic [2:0] pad_rows_q, pad_cols_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q     <= spool_pkg::RST_IN_HEIGHT;
      in_width_q      <= spool_pkg::RST_IN_WIDTH;
      kernel_height_q <= spool_pkg::RST_KERNEL_HEIGHT;
      kernel_width_q  <= spool_pkg::RST_KERNEL_WIDTH;
      stride_rows_q   <= spool_pkg::RST_STRIDE_ROWS;
      stride_cols_q   <= spool_pkg::RST_STRIDE_COLS;
      pad_rows_q      <= spool_pkg::RST_PAD_ROWS;
      pad_cols_q      <= spool_pkg::RST_PAD_COLS;
    end else if (cfg_i.valid) begin
      case (spool_pkg::cfg_reg_e'(cfg_i.index))
        spool_pkg::REG_IN_HEIGHT:     in_height_q     <= cfg_i.data[6:0];
        spool_pkg::REG_IN_WIDTH:      in_width_q      <= cfg_i.data[6:0];
        spool_pkg::REG_KERNEL_HEIGHT: kernel_height_q <= cfg_i.data[3:0];
        spool_pkg::REG_KERNEL_WIDTH:  kernel_width_q  <= cfg_i.data[3:0];
        spool_pkg::REG_STRIDE_ROWS:   stride_rows_q   <= cfg_i.data[3:0];
        spool_pkg::REG_STRIDE_COLS:   stride_cols_q   <= cfg_i.data[3:0];
        spool_pkg::REG_PAD_ROWS:      pad_rows_q      <= cfg_i.data[2:0];
        spool_pkg::REG_PAD_COLS:      pad_cols_q      <= cfg_i.data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg_o.h = (in_height_q == 7'd0) ? 7'd1 :
              (int'(in_height_q) > MAX_ROWS) ? 7'(MAX_ROWS) : in_height_q;
    cfg_o.w = (in_width_q == 7'd0) ? 7'd1 :
              (int'(in_width_q) > MAX_COLS) ? 7'(MAX_COLS) : in_width_q;
    cfg_o.kh = (kernel_height_q == 4'd0) ? 4'd1 :
               (int'(kernel_height_q) > MAX_KERNEL) ? 4'(MAX_KERNEL) : kernel_height_q;
    cfg_o.kw = (kernel_width_q == 4'd0) ? 4'd1 :
               (int'(kernel_width_q) > MAX_KERNEL) ? 4'(MAX_KERNEL) : kernel_width_q;
    cfg_o.sh = (stride_rows_q == 4'd0) ? 4'd1 :
               (int'(stride_rows_q) > spool_pkg::STRIDE_MAX) ?
               4'(spool_pkg::STRIDE_MAX) : stride_rows_q;
    cfg_o.sw = (stride_cols_q == 4'd0) ? 4'd1 :
               (int'(stride_cols_q) > spool_pkg::STRIDE_MAX) ?
               4'(spool_pkg::STRIDE_MAX) : stride_cols_q;
    cfg_o.ph = pad_rows_q;
    cfg_o.pw = pad_cols_q;
  end

endmodule

/* hdl/spool_core.sv */
// Request sequencer: pixel writes into the frame RAM and window walks that
// read, accumulate and saturate one sum. Depends on spool_pkg and spool_ifs.
module spool_core #(
  parameter int MAX_ROWS   = spool_pkg::MAX_ROWS,
  parameter int MAX_COLS   = spool_pkg::MAX_COLS,
  parameter int MAX_KERNEL = spool_pkg::MAX_KERNEL,
  parameter int DATA_WIDTH = spool_pkg::DATA_WIDTH,
  parameter int DEPTH      = MAX_ROWS * MAX_COLS,
  parameter int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spool_pkg::cfg_t       cfg_i,
  spool_req_if.sink             req_i,
  spool_rsp_if.source           rsp_o,
  output logic                  ram_we_o,
  output logic [ADDR_W-1:0]     ram_waddr_o,
  output logic [DATA_WIDTH-1:0] ram_wdata_o,
  output logic                  ram_re_o,
  output logic [ADDR_W-1:0]     ram_raddr_o,
  input  logic [DATA_WIDTH-1:0] ram_rdata_i
);

  localparam int ACC_RAW = DATA_WIDTH + $clog2(MAX_KERNEL * MAX_KERNEL + 1) + 1;
  localparam int ACC_W   = (ACC_RAW > spool_pkg::SUM_WIDTH + 1) ?
                           ACC_RAW : spool_pkg::SUM_WIDTH + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(spool_pkg::SUM_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(spool_pkg::SUM_MIN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e                    state_q, state_d;
  logic [6:0]                row_q, row_d, col_q, col_d;
  logic signed [11:0]        r_base_q, r_base_d, c_base_q, c_base_d;
  logic                      err_q, err_d;
  logic [3:0]                ki_q, ki_d, kj_q, kj_d;
  logic                      rd_pend_q, rd_pend_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [21:0]        out_sum_q, out_sum_d;
  logic                      out_status_q, out_status_d;

  logic [10:0]        prod_r, prod_c;
  logic [11:0]        reach_r, reach_c, span_r, span_c;
  logic signed [11:0] r_cur, c_cur;
  logic               in_image;
  logic               accept;
  logic               load_out;
  logic signed [ACC_W-1:0] acc_sum;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  generate
    if (DATA_WIDTH <= 16) begin : g_trunc
      assign ram_wdata_o = req_i.pixel[DATA_WIDTH-1:0];
    end else begin : g_sext
      assign ram_wdata_o = {{(DATA_WIDTH-16){req_i.pixel[15]}}, req_i.pixel};
    end
  endgenerate

  assign ram_we_o = accept && (req_i.command == spool_pkg::CMD_WRITE) &&
                    (req_i.row < cfg_i.h) && (req_i.col < cfg_i.w);
  assign ram_waddr_o = ADDR_W'(32'(req_i.row) * MAX_COLS + 32'(req_i.col));

  assign prod_r  = 11'(row_q) * 11'(cfg_i.sh);
  assign prod_c  = 11'(col_q) * 11'(cfg_i.sw);
  assign reach_r = {1'b0, prod_r} + 12'(cfg_i.kh);
  assign reach_c = {1'b0, prod_c} + 12'(cfg_i.kw);
  assign span_r  = 12'(cfg_i.h) + 12'({cfg_i.ph, 1'b0});
  assign span_c  = 12'(cfg_i.w) + 12'({cfg_i.pw, 1'b0});

  assign r_cur    = r_base_q + $signed({8'd0, ki_q});
  assign c_cur    = c_base_q + $signed({8'd0, kj_q});
  assign in_image = !r_cur[11] && ($unsigned(r_cur) < 12'(cfg_i.h)) &&
                    !c_cur[11] && ($unsigned(c_cur) < 12'(cfg_i.w));

  assign ram_re_o    = (state_q == ST_RUN) && in_image;
  assign ram_raddr_o = ADDR_W'(32'(r_cur[10:0]) * MAX_COLS + 32'(c_cur[10:0]));

  assign acc_sum = acc_q + {{(ACC_W-DATA_WIDTH){ram_rdata_i[DATA_WIDTH-1]}}, ram_rdata_i};
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    r_base_d     = r_base_q;
    c_base_d     = c_base_q;
    err_d        = err_q;
    ki_d         = ki_q;
    kj_d         = kj_q;
    rd_pend_d    = 1'b0;
    acc_d        = rd_pend_q ? acc_sum : acc_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_sum_d    = out_sum_q;
    out_status_d = out_status_q;

    case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.command == spool_pkg::CMD_COMPUTE)) begin
          row_d   = req_i.row;
          col_d   = req_i.col;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        r_base_d = $signed({1'b0, prod_r}) - $signed(12'(cfg_i.ph));
        c_base_d = $signed({1'b0, prod_c}) - $signed(12'(cfg_i.pw));
        err_d    = (reach_r > span_r) || (reach_c > span_c);
        ki_d     = 4'd0;
        kj_d     = 4'd0;
        acc_d    = '0;
        state_d  = err_d ? ST_DONE : ST_RUN;
      end
      ST_RUN: begin
        rd_pend_d = in_image;
        if (kj_q == cfg_i.kw - 4'd1) begin
          kj_d = 4'd0;
          ki_d = ki_q + 4'd1;
          if (ki_q == cfg_i.kh - 4'd1) begin
            state_d = ST_DRAIN;
          end
        end else begin
          kj_d = kj_q + 4'd1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          if (err_q) begin
            out_sum_d    = '0;
            out_status_d = spool_pkg::STATUS_RANGE;
          end else begin
            out_status_d = spool_pkg::STATUS_OK;
            if (acc_q > SAT_HI) begin
              out_sum_d = SAT_HI[21:0];
            end else if (acc_q < SAT_LO) begin
              out_sum_d = SAT_LO[21:0];
            end else begin
              out_sum_d = acc_q[21:0];
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      row_q        <= '0;
      col_q        <= '0;
      r_base_q     <= '0;
      c_base_q     <= '0;
      err_q        <= 1'b0;
      ki_q         <= '0;
      kj_q         <= '0;
      rd_pend_q    <= 1'b0;
      acc_q        <= '0;
      out_valid_q  <= 1'b0;
      out_sum_q    <= '0;
      out_status_q <= spool_pkg::STATUS_OK;
    end else begin
      state_q      <= state_d;
      row_q        <= row_d;
      col_q        <= col_d;
      r_base_q     <= r_base_d;
      c_base_q     <= c_base_d;
      err_q        <= err_d;
      ki_q         <= ki_d;
      kj_q         <= kj_d;
      rd_pend_q    <= rd_pend_d;
      acc_q        <= acc_d;
      out_valid_q  <= out_valid_d;
      out_sum_q    <= out_sum_d;
      out_status_q <= out_status_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.window_sum = out_sum_q;
  assign rsp_o.status     = out_status_q;

endmodule
